[hw/rtl/mtfs_pkg.sv]
// ----------------------------------------------------------------------------
// Move-to-front index stack package
// Shared types and constants for the index stack and its chain of cells.
// ----------------------------------------------------------------------------
package mtfs_pkg;

   // Field widths of the transfer payloads.
   localparam int IDX_W    = 8;
   localparam int COUNT_W  = 9;
   localparam int LIMIT_W  = 9;
   localparam int STATUS_W = 2;

   // Default capacity and the reset value of the index limit.
   localparam int MAX_ENTRIES_DEFAULT = 256;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

   // Largest number of distinct indices the index field can name.
   localparam int INDEX_SPACE = 1 << IDX_W;

   // Operation codes.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_RANGE = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = STATUS_W'(2);

   // Input item.
   typedef struct packed {
      logic             operation;
      logic [IDX_W-1:0] index;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [IDX_W-1:0]    popped_index;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  held_count;
   } rsp_type;

   // Contents of one stack cell.
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
   } entry_type;

   // Command broadcast along the chain of cells.
   typedef struct packed {
      logic             apply;
      logic             pop;
      logic             hit;
      logic [IDX_W-1:0] hit_pos;
      logic [IDX_W-1:0] key;
   } chain_ctl_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

endpackage

[hw/rtl/mtfs_cell.sv]
// ----------------------------------------------------------------------------
// Index stack cell
// Holds one stack slot. It compares its index with the broadcast key and
// takes the entry of its upper or lower neighbor when the stack shifts.
// ----------------------------------------------------------------------------
module mtfs_cell #(
   parameter int CELL_POS = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mtfs_pkg::chain_ctl_type ctl,
   input  mtfs_pkg::entry_type     upper,
   input  mtfs_pkg::entry_type     lower,
   output mtfs_pkg::entry_type     entry,
   output logic                    match
);
   import mtfs_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   logic [IDX_W-1:0] index_ff;
   logic [IDX_W-1:0] index_in;
   logic             shift_down;
   logic             shift_up;

   // A push moves every cell at or above the old place of the key down by one;
   // a push of a new key moves the whole stack. A pop moves the whole stack up.
   assign shift_down = ctl.apply && !ctl.pop &&
                       (!ctl.hit || (IDX_W'(CELL_POS) <= ctl.hit_pos));
   assign shift_up   = ctl.apply && ctl.pop;

   // Select the next contents of the slot.
   always_comb begin
      valid_in = valid_ff;
      index_in = index_ff;
      if (shift_down) begin
         valid_in = upper.valid;
         index_in = upper.index;
      end else if (shift_up) begin
         valid_in = lower.valid;
         index_in = lower.index;
      end
   end

   // Occupancy is control state; the index is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
   end

   assign entry.valid = valid_ff;
   assign entry.index = index_ff;
   assign match       = valid_ff && (index_ff == ctl.key);

endmodule

[hw/rtl/mtfs_chain.sv]
// ----------------------------------------------------------------------------
// Index stack cell chain
// A row of cells with the top of the stack in cell zero, plus the encoder
// that reports where the broadcast key is held.
// ----------------------------------------------------------------------------
module mtfs_chain #(
   parameter int CELL_COUNT = mtfs_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mtfs_pkg::chain_ctl_type   ctl,
   output logic                      hit,
   output logic [mtfs_pkg::IDX_W-1:0] hit_pos,
   output mtfs_pkg::entry_type       top_entry
);
   import mtfs_pkg::*;

   entry_type             entries [CELL_COUNT];
   entry_type             uppers  [CELL_COUNT];
   entry_type             lowers  [CELL_COUNT];
   logic [CELL_COUNT-1:0] match_bits;

   // Build the row and wire each cell to its neighbors. The top cell takes
   // the key on a push; the bottom cell takes an empty slot on a pop.
   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      if (k == 0) begin : g_top
         assign uppers[k] = '{valid: 1'b1, index: ctl.key};
      end else begin : g_mid
         assign uppers[k] = entries[k-1];
      end
      if (k == CELL_COUNT - 1) begin : g_bottom
         assign lowers[k] = '{valid: 1'b0, index: '0};
      end else begin : g_low
         assign lowers[k] = entries[k+1];
      end

      mtfs_cell #(
         .CELL_POS (k)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .upper (uppers[k]),
         .lower (lowers[k]),
         .entry (entries[k]),
         .match (match_bits[k])
      );
   end

   // Each index is held at most once, so the match vector is one-hot or zero
   // and the position is an OR over the masked cell numbers.
   always_comb begin
      hit_pos = '0;
      for (int k = 0; k < CELL_COUNT; k++) begin
         if (match_bits[k]) begin
            hit_pos = hit_pos | IDX_W'(k);
         end
      end
   end

   assign hit       = |match_bits;
   assign top_entry = entries[0];

endmodule

[hw/rtl/move_to_front_index_stack_core.sv]
// ----------------------------------------------------------------------------
// Move-to-front index stack core
// A request passes through a search state over the cell chain, then an update
// state that shifts the cells and registers the result. Requests are taken
// when idle or as the last one finishes; a blocked output stalls the update.
// Reset: synchronous; the stack is empty and the index limit is 256.
// ----------------------------------------------------------------------------
module move_to_front_index_stack_core #(
   parameter int MAX_ENTRIES = mtfs_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  mtfs_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output mtfs_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [mtfs_pkg::LIMIT_W-1:0] csr_wdata
);
   import mtfs_pkg::*;

   // Only indices the index field can name ever occupy a cell.
   localparam int CELL_COUNT = (MAX_ENTRIES < INDEX_SPACE) ? MAX_ENTRIES : INDEX_SPACE;

   state_type          state_ff;
   state_type          state_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               op_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic               bad_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;
   logic               req_xfer;
   logic               out_free;
   logic               finish;
   logic               range_bad;
   logic               chain_hit;
   logic [IDX_W-1:0]   chain_pos;
   entry_type          top_entry;
   chain_ctl_type      ctl;

   // Handshake.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_UPDATE) && out_free;
   assign req_stall = (state_ff != ST_IDLE) && !finish;
   assign req_xfer  = req_valid && !req_stall;

   // Sequencer: search the chain, then update it and post the result.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (finish) begin
               state_in = req_xfer ? ST_SEARCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Index limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // Capture the request on its transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff  <= req_data.operation;
         idx_ff <= req_data.index;
      end
   end

   // A push fails at or above the smaller of the limit and the capacity.
   assign range_bad = ({1'b0, idx_ff} >= limit_ff) || (32'(idx_ff) >= 32'(MAX_ENTRIES));

   // Register the search result at the end of the search cycle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_SEARCH) begin
         hit_ff <= chain_hit;
         pos_ff <= chain_pos;
         bad_ff <= (op_ff == OP_PUSH) && range_bad;
      end
   end

   // Chain command for the update cycle.
   always_comb begin
      ctl.key     = idx_ff;
      ctl.pop     = (op_ff == OP_POP);
      ctl.hit     = hit_ff;
      ctl.hit_pos = pos_ff;
      if (op_ff == OP_POP) begin
         ctl.apply = finish && (count_ff != '0);
      end else begin
         ctl.apply = finish && !bad_ff;
      end
   end

   mtfs_chain #(
      .CELL_COUNT (CELL_COUNT)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .hit       (chain_hit),
      .hit_pos   (chain_pos),
      .top_entry (top_entry)
   );

   // Count update and result formation.
   always_comb begin
      count_in                 = count_ff;
      rsp_data_in.popped_index = '0;
      rsp_data_in.status       = STATUS_OK;
      if (op_ff == OP_POP) begin
         if (count_ff == '0) begin
            rsp_data_in.status = STATUS_EMPTY;
         end else begin
            count_in                 = count_ff - COUNT_W'(1);
            rsp_data_in.popped_index = top_entry.index;
         end
      end else begin
         if (bad_ff) begin
            rsp_data_in.status = STATUS_RANGE;
         end else if (!hit_ff) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
      rsp_data_in.held_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (finish) begin
         count_ff <= count_in;
      end
   end

   // Output register: a finished result waits here while the next request
   // moves through the search cycle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The count never exceeds the number of cells.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CELL_COUNT)
      else $error("held count exceeds the cell count");

   // The top cell is occupied exactly when the stack is not empty.
   a_top_matches_count : assert property (@(posedge clock) disable iff (reset)
      top_entry.valid == (count_ff != '0))
      else $error("top cell occupancy disagrees with the held count");

   // A finished update always posts a result.
   a_finish_posts : assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("update finished without a result");

   // A successful pop lowers the count by one.
   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (finish && (op_ff == OP_POP) && (count_ff != '0)) |=>
      (count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("pop did not lower the held count");

   // The update cycle holds only while the output register is blocked.
   a_update_holds : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPDATE) && !out_free) |=> (state_ff == ST_UPDATE))
      else $error("update left while the result register was blocked");

endmodule

[dv/mtfs_stack_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front index stack monitor
// Watches the request, result and register ports of the index stack. It keeps
// its own image of the stack to predict each result, then compares every
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mtfs_stack_monitor #(
   parameter int CAPACITY = mtfs_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  mtfs_pkg::req_type            req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  mtfs_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [mtfs_pkg::LIMIT_W-1:0] csr_wdata,
   output int                           fail_count,
   output int                           outstanding
);
   import mtfs_pkg::*;

   // Image of the block: the stack with its top at position 0, a flag per
   // index that is held, and the index limit register.
   logic [LIMIT_W-1:0] limit_reg;
   logic [IDX_W-1:0]   stack_order [$];
   logic               held_mask [INDEX_SPACE];
   rsp_type            awaited_rsps [$];
   int                 mismatches = 0;

   // Apply one request to the stack image and return the result it should give.
   function automatic rsp_type apply_request(input req_type item);
      rsp_type res;
      int      cap;
      cap = (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
      res = '0;
      res.status = STATUS_OK;
      if (item.operation == OP_PUSH) begin
         if (int'(item.index) >= cap) begin
            res.status = STATUS_RANGE;
         end else if (!held_mask[item.index]) begin
            stack_order.push_front(item.index);
            held_mask[item.index] = 1'b1;
         end else if (stack_order[0] != item.index) begin
            // Already held further down: take it out and put it back on top.
            for (int k = 1; k < stack_order.size(); k++) begin
               if (stack_order[k] == item.index) begin
                  stack_order.delete(k);
                  break;
               end
            end
            stack_order.push_front(item.index);
         end
      end else if (stack_order.size() == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.popped_index = stack_order.pop_front();
         held_mask[res.popped_index] = 1'b0;
      end
      res.held_count = COUNT_W'(stack_order.size());
      return res;
   endfunction

   // Track register writes, predict on each request transfer and check each
   // result transfer.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         limit_reg = LIMIT_RESET;
         stack_order.delete();
         foreach (held_mask[i]) held_mask[i] = 1'b0;
         awaited_rsps.delete();
      end else begin
         if (csr_we) limit_reg = csr_wdata;
         if (req_valid && !req_stall) awaited_rsps.push_back(apply_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               $error("result transfer with nothing expected: %p", rsp_data);
               mismatches++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_data.popped_index !== want.popped_index) begin
                  $error("popped_index: expected %0d, got %0d",
                         want.popped_index, rsp_data.popped_index);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.held_count !== want.held_count) begin
                  $error("held_count: expected %0d, got %0d",
                         want.held_count, rsp_data.held_count);
                  mismatches++;
               end
            end
         end
      end
      outstanding <= awaited_rsps.size();
      fail_count  <= mismatches;
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front index stack testbench
// Drives pushes and pops with random gaps and result stalls, walks the index
// limit through its extremes, fills the stack to capacity, and relies on the
// monitor for prediction and checking before giving the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import mtfs_pkg::*;

   localparam int CAPACITY = MAX_ENTRIES_DEFAULT;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_we = 1'b0;
   logic [LIMIT_W-1:0] csr_wdata = '0;
   int                 fail_count;
   int                 outstanding;
   int                 sent_count = 0;
   int                 index_cap = CAPACITY;

   initial begin
      forever #1 clock = ~clock;
   end

   move_to_front_index_stack_core #(
      .MAX_ENTRIES(CAPACITY)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   mtfs_stack_monitor #(
      .CAPACITY(CAPACITY)
   ) i_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   // Offer one request, after an occasional gap, and hold it until the transfer.
   task automatic send_req(input logic op, input logic [IDX_W-1:0] idx);
      bit quiet;
      quiet = (sent_count >= 700 && sent_count < 900);
      if (!quiet && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'{op, idx};
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Write the index limit while the block is idle.
   task automatic set_limit(input logic [LIMIT_W-1:0] value);
      drain();
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      index_cap = (value > CAPACITY) ? CAPACITY : int'(value);
   endtask

   // One random request: pops, pushes from a small set of indices so that
   // moves to the top are frequent, pushes at the limit edge, and wild pushes.
   task automatic send_random(input int pool, input int pop_pct);
      int pick;
      int span;
      span = (index_cap < pool) ? index_cap : pool;
      pick = $urandom_range(99);
      if (pick < pop_pct) begin
         send_req(OP_POP, IDX_W'($urandom));
      end else if (pick < 80 && span > 0) begin
         send_req(OP_PUSH, IDX_W'($urandom_range(span - 1, 0)));
      end else if (pick < 92 && index_cap > 0) begin
         send_req(OP_PUSH, IDX_W'(index_cap - int'($urandom_range(1, 0))));
      end else begin
         send_req(OP_PUSH, IDX_W'($urandom));
      end
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      logic [IDX_W-1:0]   fill_order [INDEX_SPACE];
      logic [IDX_W-1:0]   spare;
      logic [LIMIT_W-1:0] lim;
      int                 j;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset limit: empty pop, push on top, push of the
      // top index, and moves to the top from the bottom.
      send_req(OP_POP, 8'hFF);
      send_req(OP_PUSH, 8'd0);
      send_req(OP_PUSH, 8'd255);
      send_req(OP_PUSH, 8'd255);
      send_req(OP_PUSH, 8'd0);
      send_req(OP_PUSH, 8'd128);
      send_req(OP_PUSH, 8'd255);
      send_req(OP_POP, 8'd0);
      send_req(OP_POP, 8'd0);

      // A limit of zero rejects every push but still lets held indices pop.
      set_limit('0);
      send_req(OP_PUSH, 8'd0);
      send_req(OP_PUSH, 8'd85);
      send_req(OP_POP, 8'd0);
      send_req(OP_POP, 8'd0);

      // A limit above capacity behaves as the capacity.
      set_limit('1);
      send_req(OP_PUSH, 8'd255);
      send_req(OP_PUSH, 8'd170);

      // The smallest limit: only index zero is accepted.
      set_limit(LIMIT_W'(1));
      send_req(OP_PUSH, 8'd1);
      send_req(OP_PUSH, 8'd0);
      send_req(OP_PUSH, 8'd0);

      // Lowered limit with indices held above it: pushes fail, pops return them.
      set_limit(LIMIT_W'(50));
      send_req(OP_PUSH, 8'd170);
      send_req(OP_PUSH, 8'd49);
      repeat (5) send_req(OP_POP, 8'd0);

      // Fill the stack to capacity in shuffled order, move some indices to the
      // top while full, then empty it and pop once more.
      set_limit(LIMIT_W'(256));
      for (int i = 0; i < INDEX_SPACE; i++) fill_order[i] = IDX_W'(i);
      for (int i = INDEX_SPACE - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         spare = fill_order[i];
         fill_order[i] = fill_order[j];
         fill_order[j] = spare;
      end
      for (int i = 0; i < INDEX_SPACE; i++) send_req(OP_PUSH, fill_order[i]);
      repeat (12) send_req(OP_PUSH, IDX_W'($urandom));
      repeat (CAPACITY + 1) send_req(OP_POP, IDX_W'($urandom));

      // Random phases, each under its own limit; the stack carries over.
      for (int p = 0; p < 9; p++) begin
         case (p)
            0: lim = '0;
            1: lim = '1;
            2: lim = LIMIT_W'(1);
            3: lim = LIMIT_W'(256);
            5: lim = LIMIT_W'(2);
            default: lim = LIMIT_W'($urandom_range(255, 3));
         endcase
         set_limit(lim);
         repeat (70) send_random($urandom_range(40, 4), (p % 2 == 1) ? 55 : 35);
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off that backs the block up
   // while requests keep coming, and a stretch with no stalls.
   initial begin : rsp_side
      int rsp_seen;
      int hold_left;
      bit held_once;
      rsp_seen  = 0;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) rsp_seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!held_once && rsp_seen >= 150) begin
            held_once = 1'b1;
            hold_left = 80;
            rsp_stall <= 1'b1;
         end else if (rsp_seen >= 700 && rsp_seen < 900) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 14);
         end
      end
   end

   // Watchdog for a hung run.
   initial begin : watchdog
      #400000;
      $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/mtfs_pkg.sv
hw/rtl/mtfs_cell.sv
hw/rtl/mtfs_chain.sv
hw/rtl/move_to_front_index_stack_core.sv
dv/mtfs_stack_monitor.sv
dv/tb_top.sv
